FILE: rtl/core/tbrd_pkg.sv
// tbrd_pkg: shared constants, types and the record length function
// for the tracker binary record deframer; no dependencies
package tbrd_pkg;

  // record layout
  localparam logic [5:0] HDR_LEN        = 6'd8;
  localparam logic [5:0] POS_BYTES      = 6'd12;
  localparam logic [5:0] EULER_BYTES    = 6'd12;
  localparam logic [5:0] TS_BYTES       = 6'd4;
  localparam logic [5:0] LINE_END_BYTES = 6'd2;
  localparam int         WORD_SLOTS     = 7;
  localparam logic [5:0] PAYLOAD_BYTES  = 6'(WORD_SLOTS * 4);

  // header markers
  localparam logic [7:0] MARK_FIRST  = 8'h4C;
  localparam logic [7:0] MARK_SECOND = 8'h59;

  // header byte offsets
  localparam logic [5:0] OFS_MARK_FIRST  = 6'd0;
  localparam logic [5:0] OFS_MARK_SECOND = 6'd1;
  localparam logic [5:0] OFS_STATION     = 6'd2;
  localparam logic [5:0] OFS_ERROR       = 6'd4;
  localparam logic [5:0] OFS_SIZE_LO     = 6'd6;
  localparam logic [5:0] OFS_SIZE_HI     = 6'd7;

  // number of word slots in each group
  localparam logic [2:0] POS_WORDS   = 3'd3;
  localparam logic [2:0] EULER_WORDS = 3'd3;

  // configuration register indexes
  localparam logic [1:0] REG_POSITION  = 2'd0;
  localparam logic [1:0] REG_EULER     = 2'd1;
  localparam logic [1:0] REG_TIMESTAMP = 2'd2;
  localparam logic [1:0] REG_LINE_END  = 2'd3;

  typedef struct packed {
    logic include_position;
    logic include_euler;
    logic include_timestamp;
    logic include_line_end;
  } cfg_t;

  typedef struct packed {
    logic        header_status;
    logic        size_mismatch;
    logic [7:0]  station_id;
    logic [7:0]  error_byte;
    logic [31:0] position_x;
    logic [31:0] position_y;
    logic [31:0] position_z;
    logic [31:0] euler_azimuth;
    logic [31:0] euler_elevation;
    logic [31:0] euler_roll;
    logic [31:0] time_stamp;
  } result_t;

  // total record length in bytes for the enabled fields
  function automatic logic [5:0] record_length(input cfg_t cfg);
    logic [5:0] n;
    n = HDR_LEN;
    if (cfg.include_position)  n = n + POS_BYTES;
    if (cfg.include_euler)     n = n + EULER_BYTES;
    if (cfg.include_timestamp) n = n + TS_BYTES;
    if (cfg.include_line_end)  n = n + LINE_END_BYTES;
    return n;
  endfunction

endpackage

FILE: rtl/core/tbrd_parser.sv
// tbrd_parser: byte counter, header capture and payload word assembly
// depends on tbrd_pkg
module tbrd_parser (
  input  logic             clk,
  input  logic             rst,
  input  tbrd_pkg::cfg_t   cfg,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  output logic             last_byte,
  output logic             done,
  output tbrd_pkg::result_t result
);
  import tbrd_pkg::*;

  logic [5:0]  byte_position;
  logic        header_bad;
  logic [7:0]  station_reg;
  logic [7:0]  error_reg;
  logic [15:0] size_reg;
  logic [31:0] payload_words [WORD_SLOTS];

  logic        header_bad_next;
  logic [7:0]  station_reg_next;
  logic [7:0]  error_reg_next;
  logic [15:0] size_reg_next;
  logic [31:0] payload_words_next [WORD_SLOTS];

  logic [5:0]  len;
  logic [5:0]  offset;
  logic [2:0]  euler_base;
  logic [2:0]  ts_index;

  // end of record check against the current length
  assign len       = record_length(cfg);
  assign last_byte = ({1'b0, byte_position} + 7'd1) >= {1'b0, len};
  assign done      = accept && last_byte;
  assign offset    = byte_position - HDR_LEN;

  // state update for the byte in flight
  always_comb begin
    header_bad_next  = header_bad;
    station_reg_next = station_reg;
    error_reg_next   = error_reg;
    size_reg_next    = size_reg;
    for (int i = 0; i < WORD_SLOTS; i++) begin
      payload_words_next[i] = payload_words[i];
    end
    unique case (byte_position)
      OFS_MARK_FIRST: begin
        header_bad_next = (data_byte != MARK_FIRST);
      end
      OFS_MARK_SECOND: begin
        if (data_byte != MARK_SECOND) header_bad_next = 1'b1;
      end
      OFS_STATION: begin
        station_reg_next = data_byte;
      end
      OFS_ERROR: begin
        error_reg_next = data_byte;
      end
      OFS_SIZE_LO: begin
        size_reg_next[7:0] = data_byte;
      end
      OFS_SIZE_HI: begin
        size_reg_next[15:8] = data_byte;
      end
      default: begin
        // payload bytes, little endian; line-end bytes land in slots the result does not read
        if (byte_position >= HDR_LEN && offset < PAYLOAD_BYTES) begin
          payload_words_next[offset[4:2]][{offset[1:0], 3'b000} +: 8] = data_byte;
        end
      end
    endcase
  end

  // result built from the updated state
  always_comb begin
    euler_base = cfg.include_position ? POS_WORDS : 3'd0;
    ts_index   = euler_base + (cfg.include_euler ? EULER_WORDS : 3'd0);
    result                 = '0;
    result.header_status   = header_bad_next;
    result.size_mismatch   = size_reg_next != {10'd0, len - HDR_LEN};
    result.station_id      = station_reg_next;
    result.error_byte      = error_reg_next;
    if (cfg.include_position) begin
      result.position_x = payload_words_next[0];
      result.position_y = payload_words_next[1];
      result.position_z = payload_words_next[2];
    end
    if (cfg.include_euler) begin
      result.euler_azimuth   = payload_words_next[euler_base];
      result.euler_elevation = payload_words_next[euler_base + 3'd1];
      result.euler_roll      = payload_words_next[euler_base + 3'd2];
    end
    if (cfg.include_timestamp) begin
      result.time_stamp = payload_words_next[ts_index];
    end
  end

  // record state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_bad    <= 1'b0;
      station_reg   <= '0;
      error_reg     <= '0;
      size_reg      <= '0;
      for (int i = 0; i < WORD_SLOTS; i++) begin
        payload_words[i] <= '0;
      end
    end else if (accept) begin
      byte_position <= last_byte ? 6'd0 : byte_position + 6'd1;
      header_bad    <= header_bad_next;
      station_reg   <= station_reg_next;
      error_reg     <= error_reg_next;
      size_reg      <= size_reg_next;
      for (int i = 0; i < WORD_SLOTS; i++) begin
        payload_words[i] <= payload_words_next[i];
      end
    end
  end

endmodule

FILE: rtl/core/tbrd_out_reg.sv
// tbrd_out_reg: result register with valid flag toward the output channel
// depends on tbrd_pkg
module tbrd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tbrd_pkg::result_t result_in,
  input  logic              out_ready,
  output logic              out_valid,
  output tbrd_pkg::result_t result_out
);
  import tbrd_pkg::*;

  // valid flag: set on load, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

FILE: rtl/core/tracker_binary_record_deframer_core.sv
// tracker_binary_record_deframer_core: top level, configuration registers
// and input flow control; depends on tbrd_pkg, tbrd_parser, tbrd_out_reg
//
//   channel  | signals                        | direction
//   ---------+--------------------------------+----------
//   input    | in_valid, in_ready, data_byte  | in
//   result   | out_valid, out_ready, fields   | out
//   config   | cfg_we, cfg_addr, cfg_wdata    | in
//
// one byte per cycle while in_ready is high; a record of 8 to 38 bytes gives
// its result in the cycle after its last byte, from the result register.
// the byte counter and header/word registers update on the byte transfer.
// a stalled result holds off only the last byte of the next record;
// all other bytes keep flowing.
// synchronous reset restores the default field enables and clears the record.
module tracker_binary_record_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        header_status,
  output logic        size_mismatch,
  output logic [7:0]  station_id,
  output logic [7:0]  error_byte,
  output logic [31:0] position_x,
  output logic [31:0] position_y,
  output logic [31:0] position_z,
  output logic [31:0] euler_azimuth,
  output logic [31:0] euler_elevation,
  output logic [31:0] euler_roll,
  output logic [31:0] time_stamp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic        cfg_wdata
);
  import tbrd_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    last_byte;
  logic    done;
  result_t result_next;
  result_t result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.include_position  <= 1'b1;
      cfg.include_euler     <= 1'b1;
      cfg.include_timestamp <= 1'b0;
      cfg.include_line_end  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POSITION:  cfg.include_position  <= cfg_wdata;
        REG_EULER:     cfg.include_euler     <= cfg_wdata;
        REG_TIMESTAMP: cfg.include_timestamp <= cfg_wdata;
        REG_LINE_END:  cfg.include_line_end  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // last byte waits only while a result is still held
  assign in_ready = !last_byte || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  tbrd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .done      (done),
    .result    (result_next)
  );

  tbrd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (done),
    .result_in  (result_next),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .result_out (result)
  );

  // result fields
  assign header_status   = result.header_status;
  assign size_mismatch   = result.size_mismatch;
  assign station_id      = result.station_id;
  assign error_byte      = result.error_byte;
  assign position_x      = result.position_x;
  assign position_y      = result.position_y;
  assign position_z      = result.position_z;
  assign euler_azimuth   = result.euler_azimuth;
  assign euler_elevation = result.euler_elevation;
  assign euler_roll      = result.euler_roll;
  assign time_stamp      = result.time_stamp;

endmodule
